[rtl/core/lfsa_pkg.sv]
// Shared types and constants for the lowest free slot allocator.
// Holds the request and result payloads, status codes and controller commands.
// No dependencies.
`default_nettype none

package lfsa_pkg;

	// Pool geometry: the free map is searched in groups of eight slots.
	localparam int MAX_SLOTS   = 64;
	localparam int SLOT_W      = 6;
	localparam int SIZE_W      = 7;
	localparam int GROUP_W     = 8;
	localparam int NUM_GROUPS  = MAX_SLOTS / GROUP_W;
	localparam int GRP_IDX_W   = 3;
	localparam int GRP_SEL_W   = SLOT_W - GRP_IDX_W;

	// Pool size after reset.
	localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(MAX_SLOTS);

	// Operation codes.
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EMPTY        = 2'd1;
	localparam logic [1:0] ST_BAD          = 2'd2;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

	// One request item.
	typedef struct packed {
		logic              operation;
		logic [SLOT_W-1:0] slot;
		logic              object_present;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] granted_slot;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic scan;
		logic commit;
	} lfsa_cmd_t;

endpackage

`default_nettype wire

[rtl/core/lfsa_ctrl.sv]
// Controller state machine of the slot allocator.
// Sequences capture, group scan and commit for each item; uses lfsa_pkg.
`default_nettype none

module lfsa_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	output lfsa_pkg::lfsa_cmd_t cmd
);
	import lfsa_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state: each item passes through a scan state and then a commit state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN:   state_d = S_COMMIT;
			S_COMMIT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands and the busy flag follow directly from the state.
	always_comb begin
		busy        = (state_q != S_IDLE);
		cmd.capture = (state_q == S_IDLE) && start;
		cmd.scan    = (state_q == S_SCAN);
		cmd.commit  = (state_q == S_COMMIT);
	end

endmodule

`default_nettype wire

[rtl/core/lfsa_datapath.sv]
// Datapath of the slot allocator: free map, pool size, two-level lowest
// free search and result register. Driven by lfsa_ctrl; uses lfsa_pkg.
`default_nettype none

module lfsa_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lfsa_pkg::lfsa_cmd_t cmd,
	input  lfsa_pkg::in_item_t  request,
	input  wire                 cfg_valid,
	input  wire [6:0]           cfg_data,
	output logic                done,
	output lfsa_pkg::out_item_t result
);
	import lfsa_pkg::*;

	in_item_t               req_q;
	logic [SIZE_W-1:0]      pool_q;
	logic [MAX_SLOTS-1:0]   free_q;
	logic                   done_q;
	out_item_t              result_q;

	logic [SIZE_W-1:0]      size_eff;
	logic [MAX_SLOTS-1:0]   avail;

	logic [NUM_GROUPS-1:0]  grp_hit_s1;
	logic [GRP_IDX_W-1:0]   grp_idx_s1 [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]  grp_hit_d;
	logic [GRP_IDX_W-1:0]   grp_idx_d [NUM_GROUPS];

	logic                   any_hit;
	logic [GRP_SEL_W-1:0]   grp_sel;
	logic [SLOT_W-1:0]      alloc_slot;
	logic                   rel_bad;
	logic                   rel_free;
	out_item_t              result_d;
	logic [MAX_SLOTS-1:0]   free_d;

	// Pool size saturates at the slot count; slots at or above it are never granted.
	always_comb begin
		size_eff = (pool_q > SIZE_W'(MAX_SLOTS)) ? SIZE_W'(MAX_SLOTS) : pool_q;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			avail[i] = free_q[i] && (SIZE_W'(i) < size_eff);
		end
	end

	// First search level: lowest free slot inside each group of eight.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_hit_d[g] = |avail[g*GROUP_W +: GROUP_W];
			grp_idx_d[g] = '0;
			for (int b = GROUP_W - 1; b >= 0; b--) begin
				if (avail[g*GROUP_W + b]) grp_idx_d[g] = GRP_IDX_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			grp_hit_s1 <= grp_hit_d;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_idx_s1[g] <= grp_idx_d[g];
			end
		end
	end

	// Second level: lowest group with a free slot, then the item's outcome.
	always_comb begin
		any_hit = |grp_hit_s1;
		grp_sel = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_hit_s1[g]) grp_sel = GRP_SEL_W'(g);
		end
		alloc_slot = {grp_sel, grp_idx_s1[grp_sel]};

		rel_bad  = !req_q.object_present || ({1'b0, req_q.slot} >= size_eff);
		rel_free = free_q[req_q.slot];

		result_d.status       = ST_OK;
		result_d.granted_slot = '0;
		free_d                = free_q;
		if (req_q.operation == OP_ALLOC) begin
			if (any_hit) begin
				result_d.granted_slot = alloc_slot;
				free_d[alloc_slot]    = 1'b0;
			end else begin
				result_d.status = ST_EMPTY;
			end
		end else begin
			if (rel_bad) begin
				result_d.status = ST_BAD;
			end else if (rel_free) begin
				result_d.status = ST_ALREADY_FREE;
			end else begin
				free_d[req_q.slot] = 1'b1;
			end
		end
	end

	// Request capture and result payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= request;
		if (cmd.commit)  result_q <= result_d;
	end

	// Control state: free map, pool size and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			pool_q <= POOL_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) free_q <= free_d;
			if (cfg_valid)  pool_q <= cfg_data;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[rtl/core/lowest_free_slot_allocator_core.sv]
// Top level of the lowest free slot allocator.
// Joins lfsa_ctrl and lfsa_datapath; uses lfsa_pkg.
//
//   channel   signals                      transfer
//   request   start, busy, request         start high while busy low
//   result    done, result                 done high for one cycle
//   config    cfg_valid, cfg_ready, data   cfg_valid and cfg_ready high
//
// An item is accepted at the edge that ends its start cycle; its result reaches
// the ports after the scan state, the commit state and the result register.
// busy is low again during the result cycle; the block takes no new item while
// busy, so it finishes each item before it accepts the next.
// After reset every slot is free and the pool size is 64.
// The receiver cannot stall; the config channel is always ready.
`default_nettype none

module lowest_free_slot_allocator_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  lfsa_pkg::in_item_t  request,
	output logic                done,
	output lfsa_pkg::out_item_t result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [6:0]           cfg_data
);
	import lfsa_pkg::*;

	lfsa_cmd_t cmd;

	// Sequencing of each item.
	lfsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Free map, search and result register.
	lfsa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/core/lfsa_checker.sv]
// Port-level checks for the slot allocator, bound to the top level.
// Uses lfsa_pkg for payload types and status codes.
`default_nettype none

module lfsa_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 start,
	input wire                 busy,
	input wire                 done,
	input lfsa_pkg::out_item_t result
);
	import lfsa_pkg::*;

	// An accepted item makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// Every accepted item yields a result strobe.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result missing after an accepted item");

	// A result strobe lasts one cycle and comes only once the block is idle.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("result strobe repeated or shown while busy");

	// A failed request carries a zero slot.
	a_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.granted_slot == '0))
		else $error("nonzero slot on a failed request");

endmodule

bind lowest_free_slot_allocator_core lfsa_checker u_lfsa_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for lowest_free_slot_allocator_core.
// Runs a directed table, then random phases under several pool sizes, and checks every
// result against the table or a bitmap predictor kept here. Depends on lfsa_pkg and the core RTL.
module tb_top;
	import lfsa_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 9;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int NUM_PHASES      = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam int LIMIT_CYCLES    = 200000;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One row of the directed table: either an item or a pool size write.
	typedef struct packed {
		row_kind_t         kind;
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic              present;
		logic [SIZE_W-1:0] size;
		logic              has_expect;
		logic [1:0]        status;
		logic [SLOT_W-1:0] grant;
	} stim_row_t;

	localparam int NUM_ROWS = 23;
	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// Fresh pool: grants come out lowest first.
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b1, ST_OK,           6'd0},
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b1, ST_OK,           6'd1},
		'{ROW_ITEM, OP_RELEASE, 6'd0,  1'b1, 7'd0,   1'b1, ST_OK,           6'd0},
		// Double release, release without object, release of a slot never used.
		'{ROW_ITEM, OP_RELEASE, 6'd0,  1'b1, 7'd0,   1'b1, ST_ALREADY_FREE, 6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd1,  1'b0, 7'd0,   1'b1, ST_BAD,          6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd63, 1'b1, 7'd0,   1'b1, ST_ALREADY_FREE, 6'd0},
		// The slot field of an allocate is ignored.
		'{ROW_ITEM, OP_ALLOC,   6'd63, 1'b1, 7'd0,   1'b1, ST_OK,           6'd0},
		// Empty pool: nothing to grant and every index is out of range.
		'{ROW_CFG,  OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b0, ST_OK,           6'd0},
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b1, ST_EMPTY,        6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd0,  1'b1, 7'd0,   1'b1, ST_BAD,          6'd0},
		// Oversized pool saturates to the full map.
		'{ROW_CFG,  OP_ALLOC,   6'd0,  1'b0, 7'd127, 1'b0, ST_OK,           6'd0},
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b0, ST_OK,           6'd0},
		// Shrunk pool: a slot at or above the size cannot be granted or released.
		'{ROW_CFG,  OP_ALLOC,   6'd0,  1'b0, 7'd2,   1'b0, ST_OK,           6'd0},
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b1, ST_EMPTY,        6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd2,  1'b1, 7'd0,   1'b1, ST_BAD,          6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd1,  1'b1, 7'd0,   1'b1, ST_OK,           6'd0},
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b1, ST_OK,           6'd1},
		// Grown again: the stranded slot can be released.
		'{ROW_CFG,  OP_ALLOC,   6'd0,  1'b0, 7'd64,  1'b0, ST_OK,           6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd2,  1'b1, 7'd0,   1'b1, ST_OK,           6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd63, 1'b0, 7'd0,   1'b1, ST_BAD,          6'd0},
		'{ROW_ITEM, OP_ALLOC,   6'd0,  1'b0, 7'd0,   1'b0, ST_OK,           6'd0},
		'{ROW_CFG,  OP_ALLOC,   6'd0,  1'b0, 7'd65,  1'b0, ST_OK,           6'd0},
		'{ROW_ITEM, OP_RELEASE, 6'd0,  1'b1, 7'd0,   1'b0, ST_OK,           6'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          request;
	logic              done;
	out_item_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;

	// Predictor state: one bit per slot (1 = free) and the pool size register.
	logic [MAX_SLOTS-1:0] free_slots;
	logic [SIZE_W-1:0]    pool_reg;
	out_item_t            pending_outcomes[$];
	int                   error_count = 0;

	lowest_free_slot_allocator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Number of slots that take part, with oversized settings saturated.
	function automatic int pool_limit();
		return (int'(pool_reg) > MAX_SLOTS) ? MAX_SLOTS : int'(pool_reg);
	endfunction

	// Works out the result of one item and updates the free map.
	function automatic out_item_t predict_outcome(in_item_t req);
		out_item_t res;
		int lim;
		lim = pool_limit();
		res.status = ST_OK;
		res.granted_slot = '0;
		if (req.operation == OP_ALLOC) begin
			res.status = ST_EMPTY;
			// Scan downward so the last hit is the lowest free slot.
			for (int s = lim - 1; s >= 0; s--) begin
				if (free_slots[s]) begin
					res.status = ST_OK;
					res.granted_slot = SLOT_W'(s);
				end
			end
			if (res.status == ST_OK)
				free_slots[res.granted_slot] = 1'b0;
		end else if (!req.object_present || int'(req.slot) >= lim) begin
			res.status = ST_BAD;
		end else if (free_slots[req.slot]) begin
			res.status = ST_ALREADY_FREE;
		end else begin
			free_slots[req.slot] = 1'b1;
		end
		return res;
	endfunction

	// Picks a slot in use below the pool size, starting at a random point.
	function automatic logic pick_used_slot(output logic [SLOT_W-1:0] pick);
		int lim;
		int base;
		int idx;
		lim = pool_limit();
		pick = '0;
		if (lim == 0)
			return 1'b0;
		base = $urandom_range(0, lim - 1);
		for (int k = 0; k < lim; k++) begin
			idx = (base + k) % lim;
			if (!free_slots[idx]) begin
				pick = SLOT_W'(idx);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Presents one item and holds it until the core takes it.
	task automatic send_item(input in_item_t req, input logic has_expect,
			input out_item_t typed_res);
		out_item_t predicted;
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		predicted = predict_outcome(req);
		pending_outcomes = {pending_outcomes, (has_expect ? typed_res : predicted)};
	endtask

	// Drains all outstanding results, then writes the pool size.
	task automatic write_pool_size(input logic [SIZE_W-1:0] value);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pool_reg = value;
	endtask

	// Random items: allocates and releases, the releases mostly of slots in use, plus noise and idle bursts.
	task automatic run_phase(input int alloc_pct, input int idle_pct);
		in_item_t req;
		logic [SLOT_W-1:0] used;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			req.slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
			req.object_present = ($urandom_range(0, 99) < 92);
			if ($urandom_range(0, 99) < alloc_pct) begin
				req.operation = OP_ALLOC;
			end else begin
				req.operation = OP_RELEASE;
				if ($urandom_range(0, 99) < 75 && pick_used_slot(used))
					req.slot = used;
			end
			send_item(req, 1'b0, '0);
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	// Result checker: each strobed result is matched to the oldest pending item.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no pending item: status %0d, granted_slot %0d",
					result.status, result.granted_slot);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (result.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, result.status);
					error_count++;
				end
				if (result.granted_slot !== want.granted_slot) begin
					$error("granted_slot mismatch: expected %0d, actual %0d",
						want.granted_slot, result.granted_slot);
					error_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, then drain.
	initial begin
		logic [SIZE_W-1:0] size;
		int alloc_pct;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		free_slots = '1;
		pool_reg = POOL_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG)
				write_pool_size(DIRECTED_ROWS[r].size);
			else
				send_item('{DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].slot,
					DIRECTED_ROWS[r].present}, DIRECTED_ROWS[r].has_expect,
					'{DIRECTED_ROWS[r].status, DIRECTED_ROWS[r].grant});
		end

		// Each phase sets a pool size and a mix that fills or drains the pool.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin size = 7'd64; alloc_pct = 90; end
				1: begin size = 7'd127; alloc_pct = 20; end
				2: begin size = 7'd1; alloc_pct = 50; end
				3: begin size = 7'd0; alloc_pct = 50; end
				4: begin size = 7'd65; alloc_pct = 85; end
				6: begin size = 7'd32; alloc_pct = 60; end
				8: begin size = 7'd64; alloc_pct = 95; end
				9: begin size = 7'd64; alloc_pct = 40; end
				default: begin
					size = SIZE_W'($urandom_range(0, 127));
					alloc_pct = $urandom_range(15, 90);
				end
			endcase
			write_pool_size(size);
			run_phase(alloc_pct, (p == NUM_PHASES - 1) ? 0 : 30);
		end

		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("Test completed with failures");
		$finish;
	end

endmodule
